### design/s2a_pkg.sv
// Shared constants and control types for the signed integer to decimal text converter.
package s2a_pkg;

    // Input word and decimal row geometry
    localparam int MAG_W       = 32;
    localparam int BIT_CNT_W   = $clog2(MAG_W);
    localparam int NUM_DIGITS  = 10;
    localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 8;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // Add-three threshold of the shift-and-add-3 step
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

    // Command broadcast to every digit cell
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift_up;
    } s2a_ctrl_t;

endpackage

### design/s2a_bcd_cell.sv
// One BCD digit cell: shift-and-add-3 step and digit shift toward the top of the row.
module s2a_bcd_cell
    import s2a_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  s2a_ctrl_t          ctrl,
    input  logic               carry_in,
    output logic               carry_out,
    input  logic [DIGIT_W-1:0] digit_in,
    output logic [DIGIT_W-1:0] digit_out
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    // Correct the digit before it doubles
    always_comb
    begin
        if (digit_reg >= DABBLE_MIN)
        begin
            adj = digit_reg + DABBLE_ADD;
        end
        else
        begin
            adj = digit_reg;
        end
    end

    assign carry_out = adj[DIGIT_W-1];
    assign digit_out = digit_reg;

    // Select the next digit from the broadcast command
    always_comb
    begin
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[DIGIT_W-2:0], carry_in};
        end
        else if (ctrl.shift_up)
        begin
            digit_next = digit_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

### design/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII text over a row of BCD cells.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------
//  input   | in_valid / in_stall   | value[31:0] signed
//  output  | out_valid / out_stall | text_char[7:0], last_char
//
// An item is accepted in ST_IDLE, then moved through the ten-cell digit row in 32
// shift steps, one magnitude bit per cycle (ST_CONV); leading zeros are then shifted
// out of the row (ST_STRIP) and the digits go out most significant first (ST_EMIT).
// The minus sign goes out as soon as the output slot is free, which can be while the row is still converting.
// Reset (rst_n, asynchronous, active low) empties the output register and
// returns the sequencer to idle. A stalled output holds its character and
// freezes digit emission; in_stall stays high until the last digit is queued.
module signed_int_to_decimal_ascii
    import s2a_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [MAG_W-1:0]  value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [CHAR_W-1:0]        text_char,
    output logic                     last_char
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_STRIP = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [MAG_W-1:0]       mag_reg;
    logic [MAG_W-1:0]       mag_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_next;
    logic [DIGIT_CNT_W-1:0] remain_reg;
    logic [DIGIT_CNT_W-1:0] remain_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CHAR_W-1:0]      char_reg;
    logic [CHAR_W-1:0]      char_next;
    logic                   last_reg;
    logic                   last_next;

    logic                   in_xfer;
    logic                   slot_free;
    logic                   push;
    logic [MAG_W-1:0]       value_u;
    s2a_ctrl_t              ctrl;

    logic [DIGIT_W-1:0]     digit [NUM_DIGITS];
    logic                   carry [NUM_DIGITS-1];
    logic [DIGIT_W-1:0]     top_digit;

    assign value_u   = value;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign top_digit = digit[NUM_DIGITS-1];

    // Digit row: magnitude bits enter at the bottom cell, digits leave at the top
    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        logic               cin;
        logic [DIGIT_W-1:0] din;

        if (i == 0)
        begin : g_bottom
            assign cin = mag_reg[MAG_W-1];
            assign din = '0;
        end
        else
        begin : g_inner
            assign cin = carry[i-1];
            assign din = digit[i-1];
        end

        if (i == NUM_DIGITS - 1)
        begin : g_top
            s2a_bcd_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .carry_in  (cin),
                .carry_out (),
                .digit_in  (din),
                .digit_out (digit[i])
            );
        end
        else
        begin : g_low
            s2a_bcd_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .carry_in  (cin),
                .carry_out (carry[i]),
                .digit_in  (din),
                .digit_out (digit[i])
            );
        end
    end

    // Sequence conversion, zero stripping and digit emission
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        remain_next    = remain_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        push           = 1'b0;
        ctrl           = '0;

        // Send the minus sign as soon as the output slot frees up
        if (neg_reg && slot_free && (state_reg != ST_IDLE))
        begin
            push      = 1'b1;
            char_next = CHAR_MINUS;
            last_next = 1'b0;
            neg_next  = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    neg_next     = value_u[MAG_W-1];
                    mag_next     = value_u[MAG_W-1] ? (MAG_W'(0) - value_u) : value_u;
                    bit_cnt_next = BIT_CNT_W'(MAG_W - 1);
                    remain_next  = DIGIT_CNT_W'(NUM_DIGITS);
                    ctrl.clear   = 1'b1;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.dabble  = 1'b1;
                mag_next     = {mag_reg[MAG_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP:
            begin
                if ((top_digit == '0) && (remain_reg > DIGIT_CNT_W'(1)))
                begin
                    ctrl.shift_up = 1'b1;
                    remain_next   = remain_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!neg_reg && slot_free)
                begin
                    push          = 1'b1;
                    char_next     = CHAR_ZERO + CHAR_W'(top_digit);
                    last_next     = (remain_reg == DIGIT_CNT_W'(1));
                    ctrl.shift_up = 1'b1;
                    remain_next   = remain_reg - 1'b1;
                    if (remain_reg == DIGIT_CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the output character until it is taken
    always_comb
    begin
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            neg_reg       <= 1'b0;
            bit_cnt_reg   <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            bit_cnt_reg   <= bit_cnt_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign text_char = char_reg;
    assign last_char = last_reg;

endmodule

### bench/signed_int_to_decimal_ascii_tb.sv
// Testbench for the signed integer to decimal ASCII converter: directed and random numbers.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb
    import s2a_pkg::*;
();

    // One expected character of decimal text
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } decimal_char_t;

    // One number waiting to be offered, with the idling that goes with it
    typedef struct {
        logic signed [MAG_W-1:0] num;
        bit                      drain_first;
        int unsigned             gap_mode;
        int unsigned             rx_mode;
    } number_item_t;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [MAG_W-1:0] value = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [CHAR_W-1:0]       text_char;
    logic                    last_char;

    number_item_t  pending_numbers[$];
    decimal_char_t expected_text[$];
    number_item_t  next_number;
    decimal_char_t want_char;

    int unsigned idle_left;
    int unsigned stall_left;
    int unsigned stall_draw;
    int unsigned rx_mode;
    logic        receiver_hold = 1'b0;
    int          numbers_sent;
    int          chars_checked;
    int          mismatches;

    signed_int_to_decimal_ascii dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .last_char (last_char)
    );

    // Work out the characters one number turns into, sign first, no leading zeros
    function automatic void queue_decimal_text(input logic signed [MAG_W-1:0] num);
        logic [MAG_W-1:0] raw;
        logic [MAG_W-1:0] magnitude;
        logic [3:0]       digits [NUM_DIGITS];
        int               n;
        decimal_char_t    entry;
        raw       = num;
        magnitude = raw[MAG_W-1] ? -raw : raw;
        n         = 0;
        do begin
            digits[n] = 4'(magnitude % 10);
            magnitude = magnitude / 10;
            n++;
        end while (magnitude != 0 && n < NUM_DIGITS);
        if (raw[MAG_W-1])
        begin
            entry.ch   = CHAR_MINUS;
            entry.last = 1'b0;
            expected_text.push_back(entry);
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            entry.ch   = CHAR_ZERO + digits[k];
            entry.last = (k == 0);
            expected_text.push_back(entry);
        end
    endfunction

    // Pick a number of random length and sign, now and then a full 32-bit word
    function automatic logic signed [MAG_W-1:0] draw_number();
        int unsigned n_dig;
        longint      ceiling;
        int unsigned mag;
        bit          neg;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        n_dig   = $urandom_range(1, NUM_DIGITS);
        neg     = 1'($urandom_range(0, 1));
        ceiling = 1;
        for (int i = 0; i < n_dig; i++)
            ceiling = ceiling * 10;
        ceiling = ceiling - 1;
        if (ceiling > 64'd2147483647)
            ceiling = neg ? 64'd2147483648 : 64'd2147483647;
        case ($urandom_range(0, 7))
            0:       mag = 32'(ceiling);
            1:       mag = 32'((ceiling + 1) / 10);
            default: mag = $urandom_range(0, 32'(ceiling));
        endcase
        return neg ? -mag : mag;
    endfunction

    // Sender gap: mostly none or short, a few long
    function automatic int unsigned draw_gap(input int unsigned mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver stall length for the current mode
    function automatic int unsigned draw_stall(input int unsigned mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
        begin
            if (r < 70)
                return 0;
            if (r < 95)
                return $urandom_range(1, 3);
            return $urandom_range(10, 40);
        end
        if (r < 30)
            return 0;
        if (r < 80)
            return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    function automatic void add_number(input logic signed [MAG_W-1:0] num, input bit drain,
                                       input int unsigned gap_mode, input int unsigned rx);
        number_item_t item;
        item.num         = num;
        item.drain_first = drain;
        item.gap_mode    = gap_mode;
        item.rx_mode     = rx;
        pending_numbers.push_back(item);
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sender: predict on each transfer, hold a stalled number, then idle or offer the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            value     <= '0;
            idle_left <= 0;
            rx_mode   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                queue_decimal_text(value);
                numbers_sent++;
            end
            if (in_valid && in_stall)
            begin
                in_valid <= 1'b1;
            end
            else if (idle_left != 0)
            begin
                in_valid  <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (pending_numbers.size() != 0 &&
                     !(pending_numbers[0].drain_first && expected_text.size() != 0))
            begin
                next_number = pending_numbers.pop_front();
                in_valid  <= 1'b1;
                value     <= next_number.num;
                idle_left <= draw_gap(next_number.gap_mode);
                rx_mode   <= next_number.rx_mode;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each transfer against the oldest expected character, then stall or not
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_text.size() == 0)
                begin
                    $display("%0t: unexpected character: expected none, actual 0x%02h last %0b",
                             $time, text_char, last_char);
                    mismatches++;
                end
                else
                begin
                    want_char = expected_text.pop_front();
                    chars_checked++;
                    if (text_char !== want_char.ch)
                    begin
                        $display("%0t: text_char mismatch: expected 0x%02h, actual 0x%02h",
                                 $time, want_char.ch, text_char);
                        mismatches++;
                    end
                    if (last_char !== want_char.last)
                    begin
                        $display("%0t: last_char mismatch: expected %0b, actual %0b",
                                 $time, want_char.last, last_char);
                        mismatches++;
                    end
                end
            end
            if (stall_left != 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                stall_draw = draw_stall(rx_mode);
                out_stall  <= receiver_hold || stall_draw != 0;
                stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
            end
        end
    end

    // Hold off the receiver for a long stretch while numbers keep coming
    initial
    begin
        while (numbers_sent < 60)
            @(posedge clk);
        receiver_hold <= 1'b1;
        repeat (400) @(posedge clk);
        receiver_hold <= 1'b0;
    end

    // Stimulus, reset and end of run
    initial
    begin
        // Directed: zero, digit boundaries, both extremes, alternating bit patterns
        add_number(0, 0, 0, 0);
        add_number(1, 0, 0, 0);
        add_number(-1, 0, 0, 0);
        add_number(5, 0, 0, 0);
        add_number(9, 0, 0, 0);
        add_number(10, 0, 0, 0);
        add_number(-10, 0, 0, 0);
        add_number(99, 0, 0, 0);
        add_number(-100, 0, 0, 0);
        add_number(32'sd2147483647, 0, 0, 0);
        add_number(32'sh80000000, 0, 0, 0);
        add_number(-32'sd2147483647, 0, 1, 1);
        add_number(32'sd1000000000, 0, 1, 1);
        add_number(32'sd999999999, 0, 1, 1);
        add_number(-32'sd999999999, 0, 1, 2);
        add_number(32'sd1234567890, 0, 1, 2);
        add_number(-32'sd1234567890, 0, 1, 2);
        add_number(32'sh55555555, 0, 0, 1);
        add_number(32'shAAAAAAAA, 0, 0, 1);
        add_number(0, 1, 0, 1);

        // Random: blocks with different idling, drain pauses between some blocks
        for (int i = 0; i < 160; i++)
        begin
            case (i / 30)
                0:       add_number(draw_number(), i == 0, 1, 1);
                1:       add_number(draw_number(), 0, 0, 0);
                2:       add_number(draw_number(), i == 60, 0, 1);
                3:       add_number(draw_number(), i == 110, 1, 2);
                4:       add_number(draw_number(), 0, 0, 0);
                default: add_number(draw_number(), i == 150, 1, 1);
            endcase
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_numbers.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("Converted %0d numbers, %0d characters checked, %0d mismatches.",
                 numbers_sent, chars_checked, mismatches);
        $display("Covered zero, both 32-bit extremes, digit boundaries, random lengths and signs.");
        if (mismatches == 0)
            $display("PASS signed_int_to_decimal_ascii");
        else
            $display("FAIL signed_int_to_decimal_ascii");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("Timeout with %0d characters still expected.", expected_text.size());
        $display("FAIL signed_int_to_decimal_ascii");
        $finish;
    end

endmodule

### signed_int_to_decimal_ascii.f
design/s2a_pkg.sv
design/s2a_bcd_cell.sv
design/signed_int_to_decimal_ascii.sv
bench/signed_int_to_decimal_ascii_tb.sv
